### hw/rtl/stmf_pkg.sv
// ----------------------------------------------------------------------------
// stmf_pkg
// Shared types and constants for the sorted table membership filter: table
// sizes, derived address and fill widths, request opcodes and status codes.
// ----------------------------------------------------------------------------
package stmf_pkg;

  // Id width and table depths
  localparam int ID_W         = 31;
  localparam int USER_DEPTH   = 65536;
  localparam int SECOND_DEPTH = 65536;

  // Address and fill-count widths derived from the depths
  localparam int USER_AW   = $clog2(USER_DEPTH);
  localparam int SECOND_AW = $clog2(SECOND_DEPTH);
  localparam int USER_FW   = USER_AW + 1;
  localparam int SECOND_FW = SECOND_AW + 1;

  // Search bounds must hold either table's fill count
  localparam int SRCH_W = (USER_FW > SECOND_FW) ? USER_FW : SECOND_FW;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_LOAD_USER    = 3'd0,
    OP_LOAD_SECOND  = 3'd1,
    OP_CLEAR_SECOND = 3'd2,
    OP_CHECK_THREE  = 3'd3,
    OP_CHECK_TWO    = 3'd4
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ORDER = 2'd2
  } status_e;

  // Which key the search engine is working on
  typedef enum logic [1:0] {
    KEY_FIRST  = 2'd0,
    KEY_SECOND = 2'd1,
    KEY_THIRD  = 2'd2
  } key_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PROBE
  } state_e;

endpackage

### hw/rtl/stmf_ram.sv
// ----------------------------------------------------------------------------
// stmf_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module stmf_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/sorted_table_membership_filter.sv
// ----------------------------------------------------------------------------
// sorted_table_membership_filter
// Two ascending id tables (user, second) with append loads and binary-search
// membership checks for two- and three-key records.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start_i high and busy_o low.
//   Every request gives exactly one result, shown for one cycle with
//   done_o high; the receiver cannot hold it off.
//   Loads, the clear and unused opcodes finish without leaving idle: the result
//   appears the cycle after the request and busy_o stays low, so such
//   requests can be issued every cycle.
//   Checks run one binary search per key on a shared search engine. Each
//   key takes a setup step and then probes (one memory read, compare and
//   bound update each), at most log2(depth)+1 probes. busy_o is high while
//   a check runs, and the result appears in the cycle after the last key
//   finishes.
//   Each table sits in its own one-read, one-write RAM. The last loaded id
//   is also kept in a register, so the order check needs no memory read.
//   Reset clears both fill counts and the controller; table entries are
//   not cleared and are never used above the fill count.
// ----------------------------------------------------------------------------
module sorted_table_membership_filter
  import stmf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [2:0]      opcode_i,
  input  logic [ID_W-1:0] key_first_i,
  input  logic [ID_W-1:0] key_second_i,
  input  logic [ID_W-1:0] key_third_i,
  output logic            done_o,
  output logic            keep_flag_o,
  output logic [2:0]      hit_mask_o,
  output logic [1:0]      status_o
);

  // Controller state
  state_e state_q, state_d;
  key_e   kidx_q, kidx_d;
  opcode_e op_q, op_d;

  // Latched query keys
  logic [ID_W-1:0] k1_q, k1_d, k2_q, k2_d, k3_q, k3_d;

  // Fill counts and last loaded ids
  logic [USER_FW-1:0]   user_fill_q, user_fill_d;
  logic [SECOND_FW-1:0] second_fill_q, second_fill_d;
  logic [ID_W-1:0]      user_last_q, user_last_d;
  logic [ID_W-1:0]      second_last_q, second_last_d;

  // Search bounds and current probe index
  logic [SRCH_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  // Result registers
  logic       done_q, done_d;
  logic       keep_q, keep_d;
  logic [2:0] hit_q, hit_d;
  status_e    status_q, status_d;

  // Memory ports
  logic            usr_we, sec_we;
  logic [ID_W-1:0] usr_rdata, sec_rdata;

  // Search datapath
  logic              cur_sec;
  logic [ID_W-1:0]   cur_key, cur_val;
  logic [SRCH_W-1:0] cur_fill, nlo, nhi;
  logic [SRCH_W:0]   nsum;
  logic              last_key, adv, found;
  logic [2:0]        hits_new;

  stmf_ram #(
    .DEPTH (USER_DEPTH),
    .WIDTH (ID_W)
  ) u_user_ram (
    .clk_i   (clk_i),
    .we_i    (usr_we),
    .waddr_i (user_fill_q[USER_AW-1:0]),
    .wdata_i (key_first_i),
    .raddr_i (mid_d[USER_AW-1:0]),
    .rdata_o (usr_rdata)
  );

  stmf_ram #(
    .DEPTH (SECOND_DEPTH),
    .WIDTH (ID_W)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (sec_we),
    .waddr_i (second_fill_q[SECOND_AW-1:0]),
    .wdata_i (key_first_i),
    .raddr_i (mid_d[SECOND_AW-1:0]),
    .rdata_o (sec_rdata)
  );

  // Key and table selection for the active search
  always_comb begin
    case (kidx_q)
      KEY_FIRST:  cur_key = k1_q;
      KEY_SECOND: cur_key = k2_q;
      KEY_THIRD:  cur_key = k3_q;
      default:    cur_key = k3_q;
    endcase
  end

  assign cur_sec  = (kidx_q == KEY_FIRST);
  assign cur_val  = cur_sec ? sec_rdata : usr_rdata;
  assign cur_fill = cur_sec ? SRCH_W'(second_fill_q) : SRCH_W'(user_fill_q);
  assign last_key = (kidx_q == KEY_THIRD) ||
                    ((kidx_q == KEY_SECOND) && (op_q == OP_CHECK_TWO));

  // Next bounds after a miss compare
  assign nlo  = (cur_key > cur_val) ? (mid_q + SRCH_W'(1)) : lo_q;
  assign nhi  = (cur_key > cur_val) ? hi_q : mid_q;
  assign nsum = {1'b0, nlo} + {1'b0, nhi};

  // Next state, loads and search steps
  always_comb begin
    state_d       = state_q;
    kidx_d        = kidx_q;
    op_d          = op_q;
    k1_d          = k1_q;
    k2_d          = k2_q;
    k3_d          = k3_q;
    user_fill_d   = user_fill_q;
    second_fill_d = second_fill_q;
    user_last_d   = user_last_q;
    second_last_d = second_last_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    done_d        = 1'b0;
    keep_d        = keep_q;
    hit_d         = hit_q;
    status_d      = status_q;
    usr_we        = 1'b0;
    sec_we        = 1'b0;
    adv           = 1'b0;
    found         = 1'b0;
    hits_new      = hit_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          // Default result for every new request
          keep_d   = 1'b0;
          hit_d    = 3'b000;
          status_d = STAT_OK;
          case (opcode_e'(opcode_i))
            OP_LOAD_USER: begin
              done_d = 1'b1;
              if (user_fill_q == USER_FW'(USER_DEPTH)) begin
                status_d = STAT_FULL;
              end else if ((user_fill_q != '0) && (key_first_i < user_last_q)) begin
                status_d = STAT_ORDER;
              end else begin
                usr_we      = 1'b1;
                user_fill_d = user_fill_q + USER_FW'(1);
                user_last_d = key_first_i;
              end
            end
            OP_LOAD_SECOND: begin
              done_d = 1'b1;
              if (second_fill_q == SECOND_FW'(SECOND_DEPTH)) begin
                status_d = STAT_FULL;
              end else if ((second_fill_q != '0) && (key_first_i < second_last_q)) begin
                status_d = STAT_ORDER;
              end else begin
                sec_we        = 1'b1;
                second_fill_d = second_fill_q + SECOND_FW'(1);
                second_last_d = key_first_i;
              end
            end
            OP_CLEAR_SECOND: begin
              done_d        = 1'b1;
              second_fill_d = '0;
            end
            OP_CHECK_THREE, OP_CHECK_TWO: begin
              op_d    = opcode_e'(opcode_i);
              k1_d    = key_first_i;
              k2_d    = key_second_i;
              k3_d    = key_third_i;
              kidx_d  = KEY_FIRST;
              state_d = ST_SETUP;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Start a search: issue the first probe, or miss on an empty table
      ST_SETUP: begin
        if (cur_fill == '0) begin
          adv = 1'b1;
        end else begin
          lo_d    = '0;
          hi_d    = cur_fill;
          mid_d   = cur_fill >> 1;
          state_d = ST_PROBE;
        end
      end

      // One probe per cycle: compare, narrow bounds, issue next read
      ST_PROBE: begin
        if (cur_val == cur_key) begin
          found = 1'b1;
          adv   = 1'b1;
        end else if (nlo < nhi) begin
          lo_d  = nlo;
          hi_d  = nhi;
          mid_d = nsum[SRCH_W:1];
        end else begin
          adv = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Key finished: record hit, then next key or final result
    if (adv) begin
      hits_new = hit_q | (found ? (3'b001 << kidx_q) : 3'b000);
      hit_d    = hits_new;
      if (last_key) begin
        done_d   = 1'b1;
        keep_d   = (op_q == OP_CHECK_THREE) ? (hits_new == 3'b111)
                                            : (hits_new == 3'b011);
        status_d = STAT_OK;
        state_d  = ST_IDLE;
      end else begin
        kidx_d  = key_e'(kidx_q + 2'd1);
        state_d = ST_SETUP;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      user_fill_q   <= '0;
      second_fill_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      user_fill_q   <= user_fill_d;
      second_fill_q <= second_fill_d;
      done_q        <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kidx_q        <= kidx_d;
    op_q          <= op_d;
    k1_q          <= k1_d;
    k2_q          <= k2_d;
    k3_q          <= k3_d;
    user_last_q   <= user_last_d;
    second_last_q <= second_last_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    mid_q         <= mid_d;
    keep_q        <= keep_d;
    hit_q         <= hit_d;
    status_q      <= status_d;
  end

  // Outputs
  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign keep_flag_o = keep_q;
  assign hit_mask_o  = hit_q;
  assign status_o    = status_q;

endmodule
